// ----- sv/urs_pkg.sv -----
`default_nettype none

package urs_pkg;

	// counter width default
	localparam int COUNT_BITS_DEF = 17;

	// register widths
	localparam int PRE_W     = 8;
	localparam int PULSE_W   = 8;
	localparam int TIMEOUT_W = 17;
	localparam int RANGE_W   = 10;
	localparam int CFG_DW    = 17;
	localparam int CFG_IW    = 3;
	localparam int DIST_W    = 10;
	localparam int STAT_W    = 2;

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_PRE_LOW = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_PULSE   = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_TIMEOUT = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_MIN_CM  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_MAX_CM  = 3'd4;

	// register reset values
	localparam logic [PRE_W-1:0]     PRE_LOW_RST = 8'd5;
	localparam logic [PULSE_W-1:0]   PULSE_RST   = 8'd15;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 17'd50000;
	localparam logic [RANGE_W-1:0]   MIN_CM_RST  = 10'd2;
	localparam logic [RANGE_W-1:0]   MAX_CM_RST  = 10'd400;

	// distance = width * 34 / 2000 = width * 17 / 1000, tracked incrementally
	localparam int               REM_W    = 10;
	localparam logic [REM_W:0]   REM_STEP = 11'd17;
	localparam logic [REM_W:0]   REM_MOD  = 11'd1000;

	// error marks
	localparam logic [DIST_W-1:0] DIST_NO_RISE = 10'd999;
	localparam logic [DIST_W-1:0] DIST_STUCK   = 10'd998;
	localparam logic [DIST_W-1:0] DIST_NO_ECHO = 10'd997;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_RISE = 2'd1;
	localparam logic [STAT_W-1:0] ST_STUCK   = 2'd2;
	localparam logic [STAT_W-1:0] ST_NO_ECHO = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_PRE   = 3'd1,
		PH_PULSE = 3'd2,
		PH_RISE  = 3'd3,
		PH_HIGH  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [PRE_W-1:0]     pre_low_ticks;
		logic [PULSE_W-1:0]   pulse_ticks;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [RANGE_W-1:0]   min_range_cm;
		logic [RANGE_W-1:0]   max_range_cm;
	} cfg_t;

	typedef struct packed {
		logic start_req;
		logic echo;
	} sample_t;

	typedef struct packed {
		logic              trig;
		logic              busy_res;
		logic              done_res;
		logic [DIST_W-1:0] distance;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/ultrasonic_range_sequencer_unit.sv -----
`default_nettype none
// a sample beat is held in the input register, and its result beat in the result register
// throughput: one sample beat per cycle while results are taken, set by the single-tick phase update
// between the input register and the result register
// a stalled result holds the input register, which then stops accepting
// reset: phase idle, counters and last distance/status zero, registers at defaults

module ultrasonic_range_sequencer_unit #(
	parameter int COUNT_BITS = urs_pkg::COUNT_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         sample_valid,
	output logic                        sample_ready,
	input  urs_pkg::sample_t            sample,
	output logic                        result_valid,
	input  wire                         result_ready,
	output urs_pkg::result_t            result,
	input  wire                         cfg_we,
	input  wire [urs_pkg::CFG_IW-1:0]   cfg_idx,
	input  wire [urs_pkg::CFG_DW-1:0]   cfg_wdata
);
	import urs_pkg::*;

	cfg_t                  cfg;
	logic                  valid_s1;
	sample_t               sample_s1;
	logic                  out_valid_q;
	result_t               result_q;
	logic                  advance;

	phase_t                phase_q,  phase_nxt;
	logic [COUNT_BITS-1:0] wait_q,   wait_nxt;
	logic [COUNT_BITS-1:0] width_q,  width_nxt;
	logic [COUNT_BITS-1:0] quo_q,    quo_nxt;
	logic [REM_W-1:0]      rem_q,    rem_nxt;
	logic [DIST_W-1:0]     dist_q,   dist_nxt;
	logic [STAT_W-1:0]     stat_q,   stat_nxt;
	result_t               step_res;

	urs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	urs_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.cfg       (cfg),
		.smp       (sample_s1),
		.phase_cur (phase_q),
		.wait_cur  (wait_q),
		.width_cur (width_q),
		.quo_cur   (quo_q),
		.rem_cur   (rem_q),
		.dist_cur  (dist_q),
		.stat_cur  (stat_q),
		.phase_nxt (phase_nxt),
		.wait_nxt  (wait_nxt),
		.width_nxt (width_nxt),
		.quo_nxt   (quo_nxt),
		.rem_nxt   (rem_nxt),
		.dist_nxt  (dist_nxt),
		.stat_nxt  (stat_nxt),
		.result    (step_res)
	);

	// handshake: the held sample moves on when the result slot is free or being taken
	assign advance      = valid_s1 && (!out_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// sequencer state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			width_q <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			dist_q  <= '0;
			stat_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			wait_q  <= wait_nxt;
			width_q <= width_nxt;
			quo_q   <= quo_nxt;
			rem_q   <= rem_nxt;
			dist_q  <= dist_nxt;
			stat_q  <= stat_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	// remainder of the running distance stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rem_q} < REM_MOD)
		else $error("distance remainder out of range");

	// a zero width means a zero running distance
	a_width_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(width_q == '0) |-> (quo_q == '0 && rem_q == '0))
		else $error("running distance without echo width");

	// a finished measurement leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.done_res) |=> (phase_q == PH_IDLE))
		else $error("sequencer not idle after done");

	// a stalled tick keeps its sample and the state
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sample_s1) && $stable(phase_q)))
		else $error("stalled tick lost");

endmodule

`default_nettype wire

// ----- sv/urs_cfg.sv -----
`default_nettype none

module urs_cfg (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [urs_pkg::CFG_IW-1:0]   cfg_idx,
	input  wire [urs_pkg::CFG_DW-1:0]   cfg_wdata,
	output urs_pkg::cfg_t               cfg
);
	import urs_pkg::*;

	cfg_t cfg_q;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_low_ticks <= PRE_LOW_RST;
			cfg_q.pulse_ticks   <= PULSE_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.min_range_cm  <= MIN_CM_RST;
			cfg_q.max_range_cm  <= MAX_CM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PRE_LOW: cfg_q.pre_low_ticks <= cfg_wdata[PRE_W-1:0];
				CFG_PULSE:   cfg_q.pulse_ticks   <= cfg_wdata[PULSE_W-1:0];
				CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
				CFG_MIN_CM:  cfg_q.min_range_cm  <= cfg_wdata[RANGE_W-1:0];
				CFG_MAX_CM:  cfg_q.max_range_cm  <= cfg_wdata[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- sv/urs_step.sv -----
`default_nettype none

module urs_step #(
	parameter int COUNT_BITS = urs_pkg::COUNT_BITS_DEF
) (
	input  urs_pkg::cfg_t                 cfg,
	input  urs_pkg::sample_t              smp,
	input  urs_pkg::phase_t               phase_cur,
	input  wire [COUNT_BITS-1:0]          wait_cur,
	input  wire [COUNT_BITS-1:0]          width_cur,
	input  wire [COUNT_BITS-1:0]          quo_cur,
	input  wire [urs_pkg::REM_W-1:0]      rem_cur,
	input  wire [urs_pkg::DIST_W-1:0]     dist_cur,
	input  wire [urs_pkg::STAT_W-1:0]     stat_cur,
	output urs_pkg::phase_t               phase_nxt,
	output logic [COUNT_BITS-1:0]         wait_nxt,
	output logic [COUNT_BITS-1:0]         width_nxt,
	output logic [COUNT_BITS-1:0]         quo_nxt,
	output logic [urs_pkg::REM_W-1:0]     rem_nxt,
	output logic [urs_pkg::DIST_W-1:0]    dist_nxt,
	output logic [urs_pkg::STAT_W-1:0]    stat_nxt,
	output urs_pkg::result_t              result
);
	import urs_pkg::*;

	localparam int TW = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;

	// saturating increment
	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
		bump = (&v) ? v : COUNT_BITS'(v + 1'b1);
	endfunction

	// wait limit reached or counter pinned at its top
	function automatic logic timed_out(input logic [COUNT_BITS-1:0] c,
	                                   input logic [TIMEOUT_W-1:0] lim);
		timed_out = (TW'(c) >= TW'(lim)) || (&c);
	endfunction

	// clamp to the configured range, minimum checked first
	function automatic logic [DIST_W-1:0] clamp(input logic [COUNT_BITS-1:0] q,
	                                            input logic [RANGE_W-1:0] lo,
	                                            input logic [RANGE_W-1:0] hi);
		if (q < COUNT_BITS'(lo))
			clamp = lo;
		else if (q > COUNT_BITS'(hi))
			clamp = hi;
		else
			clamp = q[DIST_W-1:0];
	endfunction

	phase_t             ph;
	logic [COUNT_BITS-1:0] wc;
	logic [COUNT_BITS-1:0] ew;
	logic [COUNT_BITS-1:0] q;
	logic [REM_W-1:0]   r;
	logic [REM_W:0]     r_sum;
	logic [DIST_W-1:0]  ld;
	logic [STAT_W-1:0]  ls;
	logic               trig;
	logic               done;
	logic               settled;

	// one tick: start, then the low, pulse and echo phases in turn;
	// empty low or pulse phases fall through within the same tick
	always_comb begin
		ph      = phase_cur;
		wc      = wait_cur;
		ew      = width_cur;
		q       = quo_cur;
		r       = rem_cur;
		ld      = dist_cur;
		ls      = stat_cur;
		trig    = 1'b0;
		done    = 1'b0;
		settled = 1'b0;
		r_sum   = {1'b0, rem_cur} + REM_STEP;

		if (ph == PH_IDLE && smp.start_req) begin
			ph = PH_PRE;
			wc = '0;
			ew = '0;
			q  = '0;
			r  = '0;
		end

		// trigger held low
		if (ph == PH_PRE) begin
			if (wc >= COUNT_BITS'(cfg.pre_low_ticks)) begin
				ph = PH_PULSE;
				wc = '0;
			end else begin
				wc      = bump(wc);
				settled = 1'b1;
			end
		end

		// trigger pulse
		if (!settled && ph == PH_PULSE) begin
			if (wc >= COUNT_BITS'(cfg.pulse_ticks)) begin
				ph = PH_RISE;
				wc = '0;
			end else begin
				trig    = 1'b1;
				wc      = bump(wc);
				settled = 1'b1;
			end
		end

		// wait for the echo to rise
		if (!settled && ph == PH_RISE) begin
			if (smp.echo) begin
				ph = PH_HIGH;
				wc = '0;
				ew = '0;
				q  = '0;
				r  = '0;
			end else begin
				wc = bump(wc);
				if (timed_out(wc, cfg.timeout_ticks)) begin
					ph   = PH_IDLE;
					ld   = DIST_NO_RISE;
					ls   = ST_NO_RISE;
					done = 1'b1;
				end
			end
			settled = 1'b1;
		end

		// time the echo high width
		if (!settled && ph == PH_HIGH) begin
			if (smp.echo) begin
				if (!(&ew)) begin
					ew = COUNT_BITS'(ew + 1'b1);
					if (r_sum >= REM_MOD) begin
						r = REM_W'(r_sum - REM_MOD);
						q = COUNT_BITS'(q + 1'b1);
					end else begin
						r = r_sum[REM_W-1:0];
					end
				end
				wc = bump(wc);
				if (timed_out(wc, cfg.timeout_ticks)) begin
					ph   = PH_IDLE;
					ld   = DIST_STUCK;
					ls   = ST_STUCK;
					done = 1'b1;
				end
			end else if (ew != '0) begin
				ph   = PH_IDLE;
				ld   = clamp(q, cfg.min_range_cm, cfg.max_range_cm);
				ls   = ST_OK;
				done = 1'b1;
			end else begin
				ph   = PH_IDLE;
				ld   = DIST_NO_ECHO;
				ls   = ST_NO_ECHO;
				done = 1'b1;
			end
			settled = 1'b1;
		end

		// unused phase codes return to idle
		if (!(ph inside {PH_IDLE, PH_PRE, PH_PULSE, PH_RISE, PH_HIGH}))
			ph = PH_IDLE;
	end

	assign phase_nxt = ph;
	assign wait_nxt  = wc;
	assign width_nxt = ew;
	assign quo_nxt   = q;
	assign rem_nxt   = r;
	assign dist_nxt  = ld;
	assign stat_nxt  = ls;

	// result beat
	always_comb begin
		result.trig     = trig;
		result.busy_res = (ph != PH_IDLE);
		result.done_res = done;
		result.distance = ld;
		result.status   = ls;
	end

endmodule

`default_nettype wire

// ----- tb/ultrasonic_range_sequencer_unit_test.sv -----
`timescale 1ns / 1ps

module ultrasonic_range_sequencer_unit_test;
	import urs_pkg::*;

	localparam int IDLE_PCT      = 28;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 2000;
	localparam int MAX_REPORTS   = 10;
	localparam int COUNT_W       = COUNT_BITS_DEF;
	// sound speed 340 m/s, round trip: cm = ticks * 34 / 2000
	localparam int unsigned SOUND_NUM = 34;
	localparam int unsigned SOUND_DEN = 2000;

	typedef logic [COUNT_W-1:0] cnt_t;
	localparam cnt_t CNT_SAT = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	sample_t             sample = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_t             result;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_idx = '0;
	logic [CFG_DW-1:0]   cfg_wdata = '0;

	// shared run state
	logic calm = 1'b0;
	int   err_count = 0;
	int   quiet_cycles = 0;
	result_t due_results[$];

	// register copies, reset values
	logic [PRE_W-1:0]     cfg_pre   = PRE_LOW_RST;
	logic [PULSE_W-1:0]   cfg_pulse = PULSE_RST;
	logic [TIMEOUT_W-1:0] cfg_tmo   = TIMEOUT_RST;
	logic [RANGE_W-1:0]   cfg_min   = MIN_CM_RST;
	logic [RANGE_W-1:0]   cfg_max   = MAX_CM_RST;

	// ranging state copy
	phase_t             ref_phase = PH_IDLE;
	cnt_t               ref_wait  = '0;
	cnt_t               ref_width = '0;
	logic [DIST_W-1:0]  ref_dist  = '0;
	logic [STAT_W-1:0]  ref_stat  = '0;

	ultrasonic_range_sequencer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ranging arithmetic
	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_SAT) ? v : v + 1'b1;
	endfunction

	function automatic logic expired(input cnt_t c);
		return (c >= cnt_t'(cfg_tmo)) || (c == CNT_SAT);
	endfunction

	// minimum is checked first, so min > max reports the minimum
	function automatic logic [DIST_W-1:0] clamp_range(input cnt_t w);
		int unsigned d;
		d = (32'(w) * SOUND_NUM) / SOUND_DEN;
		if (d < 32'(cfg_min))
			d = 32'(cfg_min);
		else if (d > 32'(cfg_max))
			d = 32'(cfg_max);
		return d[DIST_W-1:0];
	endfunction

	task automatic close_measurement(input logic [DIST_W-1:0] dist_cm,
			input logic [STAT_W-1:0] st);
		ref_dist  = dist_cm;
		ref_stat  = st;
		ref_phase = PH_IDLE;
	endtask

	// advance one tick and queue the result it produces
	task automatic ranging_step(input sample_t s);
		result_t r;
		logic    settled;
		logic    fin;
		r       = '0;
		settled = 1'b0;
		fin     = 1'b0;
		if (ref_phase == PH_IDLE && s.start_req) begin
			ref_phase = PH_PRE;
			ref_wait  = '0;
			ref_width = '0;
		end
		// zero-length phases fall through within the same tick
		while (!settled) begin
			case (ref_phase)
				PH_PRE: begin
					if (ref_wait >= cnt_t'(cfg_pre)) begin
						ref_phase = PH_PULSE;
						ref_wait  = '0;
					end else begin
						ref_wait = sat_inc(ref_wait);
						settled  = 1'b1;
					end
				end
				PH_PULSE: begin
					if (ref_wait >= cnt_t'(cfg_pulse)) begin
						ref_phase = PH_RISE;
						ref_wait  = '0;
					end else begin
						r.trig   = 1'b1;
						ref_wait = sat_inc(ref_wait);
						settled  = 1'b1;
					end
				end
				PH_RISE: begin
					if (s.echo) begin
						ref_phase = PH_HIGH;
						ref_wait  = '0;
						ref_width = '0;
					end else begin
						ref_wait = sat_inc(ref_wait);
						if (expired(ref_wait)) begin
							close_measurement(DIST_NO_RISE, ST_NO_RISE);
							fin = 1'b1;
						end
					end
					settled = 1'b1;
				end
				PH_HIGH: begin
					if (s.echo) begin
						ref_width = sat_inc(ref_width);
						ref_wait  = sat_inc(ref_wait);
						if (expired(ref_wait)) begin
							close_measurement(DIST_STUCK, ST_STUCK);
							fin = 1'b1;
						end
					end else if (ref_width != '0) begin
						close_measurement(clamp_range(ref_width), ST_OK);
						fin = 1'b1;
					end else begin
						close_measurement(DIST_NO_ECHO, ST_NO_ECHO);
						fin = 1'b1;
					end
					settled = 1'b1;
				end
				default: begin
					ref_phase = PH_IDLE;
					settled   = 1'b1;
				end
			endcase
		end
		r.busy_res = (ref_phase != PH_IDLE);
		r.done_res = fin;
		r.distance = ref_dist;
		r.status   = ref_stat;
		due_results.push_back(r);
	endtask

	// one sample beat, with random idle cycles ahead of it unless calm
	task automatic send_tick(input logic start, input logic echo_lvl);
		sample_t s;
		s.start_req = start;
		s.echo      = echo_lvl;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				sample_valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		ranging_step(s);
	endtask

	// finish any measurement, then let every result drain
	task automatic settle_block();
		while (ref_phase != PH_IDLE)
			send_tick(1'b0, ref_phase == PH_RISE);
		sample_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_PRE_LOW: cfg_pre   = data[PRE_W-1:0];
			CFG_PULSE:   cfg_pulse = data[PULSE_W-1:0];
			CFG_TIMEOUT: cfg_tmo   = data[TIMEOUT_W-1:0];
			CFG_MIN_CM:  cfg_min   = data[RANGE_W-1:0];
			CFG_MAX_CM:  cfg_max   = data[RANGE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// write all registers, junk in the unused upper bits, plus one unmapped index
	task automatic apply_settings(input logic [PRE_W-1:0] pre, input logic [PULSE_W-1:0] pulse,
			input logic [TIMEOUT_W-1:0] tmo, input logic [RANGE_W-1:0] lo_cm,
			input logic [RANGE_W-1:0] hi_cm);
		logic [CFG_DW-1:0] junk;
		junk = CFG_DW'($urandom());
		put_reg(CFG_PRE_LOW, {junk[CFG_DW-1:PRE_W], pre});
		junk = CFG_DW'($urandom());
		put_reg(CFG_PULSE, {junk[CFG_DW-1:PULSE_W], pulse});
		put_reg(CFG_TIMEOUT, CFG_DW'(tmo));
		junk = CFG_DW'($urandom());
		put_reg(CFG_MIN_CM, {junk[CFG_DW-1:RANGE_W], lo_cm});
		junk = CFG_DW'($urandom());
		put_reg(CFG_MAX_CM, {junk[CFG_DW-1:RANGE_W], hi_cm});
		put_reg(CFG_MAX_CM + CFG_IW'($urandom_range(1, 3)), CFG_DW'($urandom()));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// measurement sequences with random timing, some with a noisy echo
	task automatic run_ranging(input int n_ticks, input int rise_span, input int width_span);
		int   sent;
		int   rise_left;
		int   high_left;
		logic noisy;
		logic st;
		logic ec;
		rise_left = 0;
		high_left = 0;
		noisy     = 1'b0;
		for (sent = 0; sent < n_ticks; sent++) begin
			st = 1'($urandom_range(1));
			ec = 1'($urandom_range(1));
			case (ref_phase)
				PH_IDLE: begin
					st        = ($urandom_range(99) < 70);
					noisy     = ($urandom_range(99) < 12);
					rise_left = $urandom_range(rise_span);
					if ($urandom_range(99) < 5)
						high_left = $urandom_range(1200);
					else
						high_left = $urandom_range(width_span);
					if (st)
						ec = (rise_left == 0);
				end
				PH_PRE, PH_PULSE: ec = (rise_left == 0);
				PH_RISE: begin
					if (rise_left > 0) begin
						ec = 1'b0;
						rise_left--;
					end else begin
						ec = 1'b1;
					end
				end
				PH_HIGH: begin
					if (high_left > 0) begin
						ec = 1'b1;
						high_left--;
					end else begin
						ec = 1'b0;
					end
				end
				default: ;
			endcase
			if (noisy && (ref_phase == PH_RISE || ref_phase == PH_HIGH))
				ec = 1'($urandom_range(1));
			send_tick(st, ec);
		end
	endtask

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic check_field(input string field, input logic [DIST_W-1:0] want,
			input logic [DIST_W-1:0] got);
		if (got !== want)
			flag_error($sformatf("result %s: expected %0d, got %0d", field, want, got));
	endtask

	// result side ready, idling at random unless calm
	always @(posedge clk)
		result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (result_valid && result_ready) begin
			if (due_results.size() == 0) begin
				flag_error($sformatf("unexpected result beat %p", result));
			end else begin
				want = due_results.pop_front();
				check_field("trig", DIST_W'(want.trig), DIST_W'(result.trig));
				check_field("busy_res", DIST_W'(want.busy_res), DIST_W'(result.busy_res));
				check_field("done_res", DIST_W'(want.done_res), DIST_W'(result.done_res));
				check_field("distance", want.distance, result.distance);
				check_field("status", DIST_W'(want.status), DIST_W'(result.status));
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// idle ticks right after reset: outputs zero, echo ignored
	task automatic test_reset_state();
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		settle_block();
	endtask

	// zero pre-low and pulse, zero timeout: both timeouts on the first counted tick
	task automatic test_skipped_phases();
		apply_settings('0, '0, '0, '0, '1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		settle_block();
	endtask

	// zero width, one-tick width, rise timeout, start on the done tick
	task automatic test_echo_widths();
		apply_settings('0, '0, 17'd3, '0, '1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		settle_block();
	endtask

	// short pre-low and trigger pulse, echo rising right after it
	task automatic test_trigger_pulse();
		apply_settings(8'd1, 8'd2, 17'd3, '0, '1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		settle_block();
	endtask

	// minimum above maximum: minimum wins
	task automatic test_clamp_order();
		apply_settings('0, '0, 17'd3, 10'd5, 10'd1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		settle_block();
	endtask

	// longest pre-low and pulse, largest timeout, inverted range limits
	task automatic test_extreme_settings();
		apply_settings('1, '1, '1, '1, '0);
		run_ranging(560, 20, 200);
		settle_block();
	endtask

	// random settings; first phase uses the reset values without idling
	task automatic test_random_ranging();
		int k;
		int tmo;
		for (k = 0; k < 6; k++) begin
			calm = (k == 0);
			if (k == 0) begin
				apply_settings(PRE_LOW_RST, PULSE_RST, TIMEOUT_RST, MIN_CM_RST, MAX_CM_RST);
				run_ranging(140, 10, 300);
			end else if (k % 3 == 2) begin
				tmo = $urandom_range(300, 1500);
				apply_settings(PRE_W'($urandom_range(4)), PULSE_W'($urandom_range(4)),
					TIMEOUT_W'(tmo), '0, RANGE_W'($urandom_range(2)));
				run_ranging(140, 20, 400);
			end else begin
				tmo = $urandom_range(40);
				apply_settings(PRE_W'($urandom_range(4)), PULSE_W'($urandom_range(4)),
					TIMEOUT_W'(tmo), RANGE_W'($urandom_range(3)), RANGE_W'($urandom_range(4)));
				run_ranging(140, tmo + 3, tmo + 3);
			end
			settle_block();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_skipped_phases();
		test_echo_widths();
		test_trigger_pulse();
		test_clamp_order();
		test_extreme_settings();
		test_random_ranging();
		settle_block();
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- ultrasonic_range_sequencer_unit.f -----
sv/urs_pkg.sv
sv/urs_cfg.sv
sv/urs_step.sv
sv/ultrasonic_range_sequencer_unit.sv
tb/ultrasonic_range_sequencer_unit_test.sv
